// ===== design/swept_aabb_collision_macros.svh =====
`ifndef SWEPT_AABB_COLLISION_MACROS_SVH
`define SWEPT_AABB_COLLISION_MACROS_SVH

// clocked assertion, expects clk and rst_n in the enclosing scope
`define SWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, written as an implication
`define SWA_ASSERT_IMP(lbl, ante, cons, msg) \
  `SWA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== design/swa_pkg.sv =====
`default_nettype none
package swa_pkg;

  localparam int COORD_W            = 16;
  localparam int DIFF_W             = COORD_W + 1;
  localparam int PROD_W             = 2 * DIFF_W;
  localparam int OUT_TIME_W         = 16;
  localparam int TIME_FRAC_BITS_DEF = 15;
  localparam int FRONT_STAGES       = 2;
  localparam int CMP_STAGES         = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic        [COORD_W-1:0] mag_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef enum logic [2:0] {
    SIDE_NONE   = 3'd0,
    SIDE_LEFT   = 3'd1,
    SIDE_RIGHT  = 3'd2,
    SIDE_TOP    = 3'd3,
    SIDE_BOTTOM = 3'd4
  } side_t;

  typedef struct packed {
    coord_t mover_left;
    coord_t mover_top;
    coord_t mover_right;
    coord_t mover_bottom;
    coord_t speed_x;
    coord_t speed_y;
    coord_t other_left;
    coord_t other_top;
    coord_t other_right;
    coord_t other_bottom;
  } item_t;

  // per-axis distances, already signed by the direction of motion
  typedef struct packed {
    logic  overlap;
    logic  zx;
    logic  zy;
    mag_t  ax;
    mag_t  ay;
    diff_t nxe;
    diff_t nxx;
    diff_t nye;
    diff_t nyx;
    logic  dxe_neg;
    logic  dye_neg;
  } sweep_t;

  // side is SIDE_NONE when there is no hit
  typedef struct packed {
    side_t side;
    mag_t  num;
    mag_t  den;
  } div_req_t;

endpackage
`default_nettype wire

// ===== design/swa_in_if.sv =====
`default_nettype none
interface swa_in_if import swa_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t mover_left;
  coord_t mover_top;
  coord_t mover_right;
  coord_t mover_bottom;
  coord_t speed_x;
  coord_t speed_y;
  coord_t other_left;
  coord_t other_top;
  coord_t other_right;
  coord_t other_bottom;

  modport source (
    output valid, mover_left, mover_top, mover_right, mover_bottom, speed_x, speed_y,
    output other_left, other_top, other_right, other_bottom,
    input  ready
  );
  modport sink (
    input  valid, mover_left, mover_top, mover_right, mover_bottom, speed_x, speed_y,
    input  other_left, other_top, other_right, other_bottom,
    output ready
  );
endinterface
`default_nettype wire

// ===== design/swa_out_if.sv =====
`default_nettype none
interface swa_out_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  hit_side;
  logic [15:0] entry_time;

  modport source (output valid, hit_side, entry_time, input ready);
  modport sink (input valid, hit_side, entry_time, output ready);
endinterface
`default_nettype wire

// ===== design/swa_front.sv =====
`default_nettype none
module swa_front import swa_pkg::*; (
  input  wire logic                    clk,
  input  wire logic [FRONT_STAGES-1:0] en,
  input  wire item_t                   item,
  output sweep_t                       sweep
);

  diff_t  dxe_r, dxx_r, dye_r, dyx_r;
  diff_t  bl_r, bt_r, br_r, bb_r;
  coord_t ol_r, ot_r, or_r, ob_r;
  logic   vxneg_r, vyneg_r, zx_r, zy_r;
  mag_t   ax_r, ay_r;
  sweep_t sweep_r;

  diff_t ml, mt, mr, mb, vx, vy, ol, ot, orr, ob;
  logic  vxpos, vypos;
  diff_t dxe_nxt, dxx_nxt, dye_nxt, dyx_nxt, bl_nxt, bt_nxt, br_nxt, bb_nxt;
  sweep_t sweep_nxt;

  always_comb begin
    ml  = {item.mover_left[COORD_W-1],   item.mover_left};
    mt  = {item.mover_top[COORD_W-1],    item.mover_top};
    mr  = {item.mover_right[COORD_W-1],  item.mover_right};
    mb  = {item.mover_bottom[COORD_W-1], item.mover_bottom};
    vx  = {item.speed_x[COORD_W-1],      item.speed_x};
    vy  = {item.speed_y[COORD_W-1],      item.speed_y};
    ol  = {item.other_left[COORD_W-1],   item.other_left};
    ot  = {item.other_top[COORD_W-1],    item.other_top};
    orr = {item.other_right[COORD_W-1],  item.other_right};
    ob  = {item.other_bottom[COORD_W-1], item.other_bottom};
    vxpos = !item.speed_x[COORD_W-1] && (item.speed_x != '0);
    vypos = !item.speed_y[COORD_W-1] && (item.speed_y != '0);
    // broad-phase box widened by the displacement
    bl_nxt  = vxpos ? ml : ml + vx;
    br_nxt  = vxpos ? mr + vx : mr;
    bt_nxt  = vypos ? mt : mt + vy;
    bb_nxt  = vypos ? mb + vy : mb;
    dxe_nxt = vxpos ? ol - mr : orr - ml;
    dxx_nxt = vxpos ? orr - ml : ol - mr;
    dye_nxt = vypos ? ot - mb : ob - mt;
    dyx_nxt = vypos ? ob - mt : ot - mb;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dxe_r   <= dxe_nxt;
      dxx_r   <= dxx_nxt;
      dye_r   <= dye_nxt;
      dyx_r   <= dyx_nxt;
      bl_r    <= bl_nxt;
      bt_r    <= bt_nxt;
      br_r    <= br_nxt;
      bb_r    <= bb_nxt;
      ol_r    <= item.other_left;
      ot_r    <= item.other_top;
      or_r    <= item.other_right;
      ob_r    <= item.other_bottom;
      vxneg_r <= item.speed_x[COORD_W-1];
      vyneg_r <= item.speed_y[COORD_W-1];
      zx_r    <= (item.speed_x == '0);
      zy_r    <= (item.speed_y == '0);
      ax_r    <= item.speed_x[COORD_W-1] ? mag_t'(-item.speed_x) : mag_t'(item.speed_x);
      ay_r    <= item.speed_y[COORD_W-1] ? mag_t'(-item.speed_y) : mag_t'(item.speed_y);
    end
  end

  always_comb begin
    sweep_nxt.overlap = (bl_r <= diff_t'(or_r)) && (br_r >= diff_t'(ol_r)) &&
                        (bt_r <= diff_t'(ob_r)) && (bb_r >= diff_t'(ot_r));
    sweep_nxt.zx      = zx_r;
    sweep_nxt.zy      = zy_r;
    sweep_nxt.ax      = ax_r;
    sweep_nxt.ay      = ay_r;
    // fold the sign of the speed into the distance so the divisor is positive
    sweep_nxt.nxe     = vxneg_r ? -dxe_r : dxe_r;
    sweep_nxt.nxx     = vxneg_r ? -dxx_r : dxx_r;
    sweep_nxt.nye     = vyneg_r ? -dye_r : dye_r;
    sweep_nxt.nyx     = vyneg_r ? -dyx_r : dyx_r;
    sweep_nxt.dxe_neg = dxe_r[DIFF_W-1];
    sweep_nxt.dye_neg = dye_r[DIFF_W-1];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sweep_r <= sweep_nxt;
    end
  end

  assign sweep = sweep_r;

endmodule
`default_nettype wire

// ===== design/swa_cmp.sv =====
`default_nettype none
module swa_cmp import swa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic [CMP_STAGES-1:0] en,
  input  wire sweep_t                sweep,
  output div_req_t                   req
);

  prod_t    pxe_ay_r, pye_ax_r, pyx_ax_r, pxx_ay_r;
  logic     xe_gt_xx_r, ye_gt_yx_r, xe_gt1_r, ye_gt1_r, negx_r, negy_r;
  logic     zx_r, zy_r, overlap_r, dxe_neg_r, dye_neg_r;
  mag_t     nxe_r, nye_r, ax_r, ay_r;
  div_req_t req_r;

  diff_t    sax, say;
  logic     xgt, xe_gt_yx, ye_gt_xx, hit;
  div_req_t req_nxt;

  assign sax = {1'b0, sweep.ax};
  assign say = {1'b0, sweep.ay};

  // cross products for comparing ratios with different divisors
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pxe_ay_r   <= sweep.nxe * say;
      pye_ax_r   <= sweep.nye * sax;
      pyx_ax_r   <= sweep.nyx * sax;
      pxx_ay_r   <= sweep.nxx * say;
      xe_gt_xx_r <= sweep.nxe > sweep.nxx;
      ye_gt_yx_r <= sweep.nye > sweep.nyx;
      xe_gt1_r   <= sweep.nxe > sax;
      ye_gt1_r   <= sweep.nye > say;
      negx_r     <= sweep.zx || sweep.nxe[DIFF_W-1];
      negy_r     <= sweep.zy || sweep.nye[DIFF_W-1];
      zx_r       <= sweep.zx;
      zy_r       <= sweep.zy;
      overlap_r  <= sweep.overlap;
      dxe_neg_r  <= sweep.dxe_neg;
      dye_neg_r  <= sweep.dye_neg;
      nxe_r      <= sweep.nxe[COORD_W-1:0];
      nye_r      <= sweep.nye[COORD_W-1:0];
      ax_r       <= sweep.ax;
      ay_r       <= sweep.ay;
    end
  end

  // a zero speed gives an entry of minus infinity and an exit of plus infinity
  always_comb begin
    xgt      = !zx_r && (zy_r || (pxe_ay_r > pye_ax_r));
    xe_gt_yx = !zx_r && !zy_r && (pxe_ay_r > pyx_ax_r);
    ye_gt_xx = !zx_r && !zy_r && (pye_ax_r > pxx_ay_r);
    // later entry after earlier exit iff some entry is after some exit
    hit = overlap_r &&
          !((!zx_r && xe_gt_xx_r) || (!zy_r && ye_gt_yx_r) || xe_gt_yx || ye_gt_xx ||
            (negx_r && negy_r) || (!zx_r && xe_gt1_r) || (!zy_r && ye_gt1_r));
    if (!hit) begin
      req_nxt.side = SIDE_NONE;
    end else if (xgt) begin
      req_nxt.side = dxe_neg_r ? SIDE_RIGHT : SIDE_LEFT;
    end else begin
      req_nxt.side = dye_neg_r ? SIDE_BOTTOM : SIDE_TOP;
    end
    req_nxt.num = xgt ? nxe_r : nye_r;
    req_nxt.den = xgt ? ax_r : ay_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      req_r <= req_nxt;
    end
  end

  assign req = req_r;

endmodule
`default_nettype wire

// ===== design/swa_div.sv =====
`default_nettype none
module swa_div import swa_pkg::*; #(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic [TIME_FRAC_BITS:0] en,
  input  wire div_req_t                req,
  output side_t                        side,
  output logic [OUT_TIME_W-1:0]        entry_time
);

  localparam int NDIV = TIME_FRAC_BITS + 1;
  localparam int QW   = TIME_FRAC_BITS + 1;
  localparam logic [QW-1:0] TIME_ONE = QW'(1) << TIME_FRAC_BITS;

  mag_t          r_r   [NDIV];
  mag_t          den_r [NDIV];
  logic [QW-1:0] q_r   [NDIV];
  side_t         side_r[NDIV];

  // first step yields the integer bit, the rest one fraction bit each
  logic ge0;
  assign ge0 = req.num >= req.den;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_r[0]    <= ge0 ? req.num - req.den : req.num;
      den_r[0]  <= req.den;
      q_r[0]    <= QW'(ge0);
      side_r[0] <= req.side;
    end
  end

  for (genvar k = 1; k < NDIV; k++) begin : g_step
    logic [COORD_W:0] rs, dw, diff;
    logic             ge;
    assign rs   = {r_r[k-1], 1'b0};
    assign dw   = {1'b0, den_r[k-1]};
    assign diff = rs - dw;
    assign ge   = rs >= dw;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        r_r[k]    <= ge ? diff[COORD_W-1:0] : rs[COORD_W-1:0];
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= {q_r[k-1][QW-2:0], ge};
        side_r[k] <= side_r[k-1];
      end
    end
  end

  logic [QW-1:0] tsel;
  assign tsel = (side_r[NDIV-1] == SIDE_NONE) ? TIME_ONE : q_r[NDIV-1];
  assign side = side_r[NDIV-1];

  if (QW > OUT_TIME_W) begin : g_sat
    assign entry_time = (|tsel[QW-1:OUT_TIME_W]) ? '1 : tsel[OUT_TIME_W-1:0];
  end else begin : g_nosat
    assign entry_time = OUT_TIME_W'(tsel);
  end

endmodule
`default_nettype wire

// ===== design/swept_aabb_collision.sv =====
// channel  dir  payload                                         handshake
// in_ch    in   mover box, speed_x/speed_y, other box (Q12.4)   valid/ready
// out_ch   out  hit_side, entry_time (Q1.15 by default)         valid/ready
//
// one box pair per cycle while out_ch is not stalled
// two stages of broad phase and distances, a multiply stage, a compare stage,
// then a restoring divider with one quotient bit per stage
// rst_n is synchronous and clears only the stage valid bits
// each stage holds while the one after it is full and stalled; bubbles close up
`default_nettype none
module swept_aabb_collision import swa_pkg::*; #(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  swa_in_if.sink   in_ch,
  swa_out_if.source out_ch
);

  localparam int NDIV = TIME_FRAC_BITS + 1;
  localparam int NST  = FRONT_STAGES + CMP_STAGES + NDIV;

  logic [NST-1:0] v_r, v_nxt, en;
  item_t          item;
  sweep_t         sweep;
  div_req_t       req;
  side_t          side;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ch.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_ch.valid : v_r[0];
    for (int i = 1; i < NST; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready = en[0];

  always_comb begin
    item.mover_left   = in_ch.mover_left;
    item.mover_top    = in_ch.mover_top;
    item.mover_right  = in_ch.mover_right;
    item.mover_bottom = in_ch.mover_bottom;
    item.speed_x      = in_ch.speed_x;
    item.speed_y      = in_ch.speed_y;
    item.other_left   = in_ch.other_left;
    item.other_top    = in_ch.other_top;
    item.other_right  = in_ch.other_right;
    item.other_bottom = in_ch.other_bottom;
  end

  swa_front u_front (
    .clk   (clk),
    .en    (en[FRONT_STAGES-1:0]),
    .item  (item),
    .sweep (sweep)
  );

  swa_cmp u_cmp (
    .clk   (clk),
    .en    (en[FRONT_STAGES+CMP_STAGES-1:FRONT_STAGES]),
    .sweep (sweep),
    .req   (req)
  );

  swa_div #(
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_div (
    .clk        (clk),
    .en         (en[NST-1:FRONT_STAGES+CMP_STAGES]),
    .req        (req),
    .side       (side),
    .entry_time (out_ch.entry_time)
  );

  assign out_ch.valid    = v_r[NST-1];
  assign out_ch.hit_side = side;

endmodule
`default_nettype wire

// ===== design/swa_checker.sv =====
`default_nettype none
`include "swept_aabb_collision_macros.svh"
module swa_checker import swa_pkg::*; #(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  hit_side,
  input wire logic [15:0] entry_time
);

  localparam logic [15:0] TIME_NONE =
    (TIME_FRAC_BITS >= 16) ? 16'hFFFF : 16'(32'd1 << TIME_FRAC_BITS);

  `SWA_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 out_valid && $stable(hit_side) && $stable(entry_time), "stalled result changed")
  `SWA_ASSERT_IMP(a_side_range, out_valid, hit_side <= SIDE_BOTTOM, "hit side code out of range")
  `SWA_ASSERT_IMP(a_miss_time, out_valid && hit_side == SIDE_NONE, entry_time == TIME_NONE, "miss without full step time")
  `SWA_ASSERT_IMP(a_hit_time, out_valid && hit_side != SIDE_NONE, entry_time <= TIME_NONE, "hit time beyond one step")
  `SWA_ASSERT_IMP(a_no_block, !out_valid || out_ready, in_ready, "input blocked with free output")

endmodule

bind swept_aabb_collision swa_checker #(
  .TIME_FRAC_BITS (TIME_FRAC_BITS)
) u_swa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .hit_side   (out_ch.hit_side),
  .entry_time (out_ch.entry_time)
);
`default_nettype wire

// ===== tb/sv/tb_swept_aabb_collision.sv =====
module tb_swept_aabb_collision;
  import swa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TFB = TIME_FRAC_BITS_DEF;
  localparam int LATENCY = 5 + TFB;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    side_t       side;
    logic [15:0] etime;
  } hit_t;

  // sweep time: inf -1/+1 or finite num/den with den > 0
  typedef struct {
    int     inf;
    longint num;
    longint den;
  } stime_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  longint cycle_cnt = 0;
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_hits = 0;
  bit hold_tx = 1'b0;
  bit in_acc = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;

  item_t pending_items[$];
  hit_t  hit_expect[$];

  swa_in_if  in_ch ();
  swa_out_if out_ch ();

  swept_aabb_collision u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic stime_t mk_time(longint span, longint spd, int inf_sign);
    stime_t t;
    if (spd == 0) begin
      t.inf = inf_sign;
      t.num = 0;
      t.den = 1;
    end else begin
      t.inf = 0;
      t.num = (spd < 0) ? -span : span;
      t.den = (spd < 0) ? -spd : spd;
    end
    return t;
  endfunction

  function automatic int cmp_t(stime_t a, stime_t b);
    longint l;
    longint r;
    if (a.inf != 0 || b.inf != 0) begin
      if (a.inf == b.inf) return 0;
      if (a.inf == -1 || b.inf == 1) return -1;
      return 1;
    end
    l = a.num * b.den;
    r = b.num * a.den;
    return (l > r) ? 1 : (l < r) ? -1 : 0;
  endfunction

  function automatic hit_t sweep_hit(item_t it);
    hit_t h;
    longint ml, mt, mr, mb, vx, vy, ol, ot, orr, ob;
    longint bl, bt, br, bb, dxe, dxx, dye, dyx;
    stime_t xe, xx, ye, yx, ent, ext;
    bit neg_x, neg_y;
    longint q;
    ml = it.mover_left;   mt = it.mover_top;
    mr = it.mover_right;  mb = it.mover_bottom;
    vx = it.speed_x;      vy = it.speed_y;
    ol = it.other_left;   ot = it.other_top;
    orr = it.other_right; ob = it.other_bottom;
    h.side = SIDE_NONE;
    h.etime = 16'(1 << TFB);
    bl = vx > 0 ? ml : ml + vx;
    br = vx > 0 ? mr + vx : mr;
    bt = vy > 0 ? mt : mt + vy;
    bb = vy > 0 ? mb + vy : mb;
    if (bl <= orr && br >= ol && bt <= ob && bb >= ot) begin
      dxe = vx > 0 ? ol - mr : orr - ml;
      dxx = vx > 0 ? orr - ml : ol - mr;
      dye = vy > 0 ? ot - mb : ob - mt;
      dyx = vy > 0 ? ob - mt : ot - mb;
      xe = mk_time(dxe, vx, -1);
      xx = mk_time(dxx, vx, 1);
      ye = mk_time(dye, vy, -1);
      yx = mk_time(dyx, vy, 1);
      ent = cmp_t(xe, ye) >= 0 ? xe : ye;
      ext = cmp_t(xx, yx) <= 0 ? xx : yx;
      neg_x = xe.inf < 0 || (xe.inf == 0 && xe.num < 0);
      neg_y = ye.inf < 0 || (ye.inf == 0 && ye.num < 0);
      if (!(cmp_t(ent, ext) > 0 || (neg_x && neg_y) ||
            xe.inf > 0 || (xe.inf == 0 && xe.num > xe.den) ||
            ye.inf > 0 || (ye.inf == 0 && ye.num > ye.den))) begin
        if (cmp_t(xe, ye) > 0) h.side = dxe < 0 ? SIDE_RIGHT : SIDE_LEFT;
        else h.side = dye < 0 ? SIDE_BOTTOM : SIDE_TOP;
        if (ent.inf == 0 && ent.num >= 0) begin
          q = (ent.num <<< TFB) / ent.den;
          h.etime = q > 65535 ? 16'hFFFF : 16'(q);
        end else begin
          h.etime = 16'd0;
        end
      end
    end
    return h;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic coord_t rnd_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return coord_t'($urandom);
    if (r == 1) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return coord_t'($signed($urandom_range(0, 2047)) - 1024);
  endfunction

  // box pair built so that a hit is likely: other box placed along the sweep
  function automatic item_t rnd_sweep();
    item_t it;
    int w, hgt, ow, oh;
    it.mover_left = coord_t'($signed($urandom_range(0, 1023)) - 512);
    it.mover_top  = coord_t'($signed($urandom_range(0, 1023)) - 512);
    w = $urandom_range(0, 200);
    hgt = $urandom_range(0, 200);
    it.mover_right  = coord_t'(it.mover_left + w);
    it.mover_bottom = coord_t'(it.mover_top + hgt);
    it.speed_x = $urandom_range(0, 5) == 0 ? 16'sd0
               : coord_t'($signed($urandom_range(0, 800)) - 400);
    it.speed_y = $urandom_range(0, 5) == 0 ? 16'sd0
               : coord_t'($signed($urandom_range(0, 800)) - 400);
    ow = $urandom_range(0, 200);
    oh = $urandom_range(0, 200);
    it.other_left = coord_t'(it.mover_left
                  + (it.speed_x * $signed($urandom_range(0, 12))) / 10
                  + ($signed($urandom_range(0, 100)) - 50));
    it.other_top  = coord_t'(it.mover_top
                  + (it.speed_y * $signed($urandom_range(0, 12))) / 10
                  + ($signed($urandom_range(0, 100)) - 50));
    it.other_right  = coord_t'(it.other_left + ow);
    it.other_bottom = coord_t'(it.other_top + oh);
    return it;
  endfunction

  function automatic item_t mk_item(int ml, int mt, int mr, int mb, int vx, int vy,
                                    int ol, int ot, int orr, int ob);
    item_t it;
    it.mover_left = coord_t'(ml);  it.mover_top = coord_t'(mt);
    it.mover_right = coord_t'(mr); it.mover_bottom = coord_t'(mb);
    it.speed_x = coord_t'(vx);     it.speed_y = coord_t'(vy);
    it.other_left = coord_t'(ol);  it.other_top = coord_t'(ot);
    it.other_right = coord_t'(orr); it.other_bottom = coord_t'(ob);
    return it;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_acc) begin
      // hold the transaction
    end else begin
      if (in_ch.valid) n_sent <= n_sent + 1;
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (hold_tx || pending_items.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        item_t it;
        it = pending_items.pop_front();
        in_ch.mover_left <= it.mover_left;     in_ch.mover_top <= it.mover_top;
        in_ch.mover_right <= it.mover_right;   in_ch.mover_bottom <= it.mover_bottom;
        in_ch.speed_x <= it.speed_x;           in_ch.speed_y <= it.speed_y;
        in_ch.other_left <= it.other_left;     in_ch.other_top <= it.other_top;
        in_ch.other_right <= it.other_right;   in_ch.other_bottom <= it.other_bottom;
        in_ch.valid <= 1'b1;
        tx_gap <= pick_gap();
      end
    end
  end

  // expectation is pushed at the accepting edge
  always @(posedge clk) begin
    in_acc <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      item_t it;
      it.mover_left = in_ch.mover_left;     it.mover_top = in_ch.mover_top;
      it.mover_right = in_ch.mover_right;   it.mover_bottom = in_ch.mover_bottom;
      it.speed_x = in_ch.speed_x;           it.speed_y = in_ch.speed_y;
      it.other_left = in_ch.other_left;     it.other_top = in_ch.other_top;
      it.other_right = in_ch.other_right;   it.other_bottom = in_ch.other_bottom;
      hit_expect.push_back(sweep_hit(it));
    end
  end

  // result ready with random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      rx_gap <= pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      hit_t e;
      n_recv <= n_recv + 1;
      if (hit_expect.size() == 0) begin
        $error("unexpected result transaction: hit_side %0d entry_time %0d",
               out_ch.hit_side, out_ch.entry_time);
        errors++;
      end else begin
        e = hit_expect.pop_front();
        if (e.side != SIDE_NONE) n_hits <= n_hits + 1;
        if (out_ch.hit_side !== e.side) begin
          $error("hit_side mismatch: expected %0d actual %0d", e.side, out_ch.hit_side);
          errors++;
        end
        if (out_ch.entry_time !== e.etime) begin
          $error("entry_time mismatch: expected %0d actual %0d", e.etime,
                 out_ch.entry_time);
          errors++;
        end
      end
    end
  end

  initial begin
    int n_rand;
    in_ch.valid = 1'b0;
    in_ch.mover_left = '0;  in_ch.mover_top = '0;
    in_ch.mover_right = '0; in_ch.mover_bottom = '0;
    in_ch.speed_x = '0;     in_ch.speed_y = '0;
    in_ch.other_left = '0;  in_ch.other_top = '0;
    in_ch.other_right = '0; in_ch.other_bottom = '0;
    out_ch.ready = 1'b0;
    hold_tx = 1'b1;

    // directed: each side, touching, zero speeds, inverted boxes, extremes
    pending_items.push_back(mk_item(0, 0, 16, 16, 32, 0, 40, 0, 60, 16));
    pending_items.push_back(mk_item(100, 0, 116, 16, -32, 0, 70, 0, 90, 16));
    pending_items.push_back(mk_item(0, 0, 16, 16, 0, 32, 0, 40, 16, 60));
    pending_items.push_back(mk_item(0, 100, 16, 116, 0, -32, 0, 70, 16, 90));
    pending_items.push_back(mk_item(0, 0, 16, 16, 16, 0, 32, 0, 48, 16));
    pending_items.push_back(mk_item(0, 0, 16, 16, 0, 0, 8, 8, 30, 30));
    pending_items.push_back(mk_item(0, 0, 16, 16, 0, 0, 100, 100, 130, 130));
    pending_items.push_back(mk_item(0, 0, 16, 16, 20, 20, 30, 30, 50, 50));
    pending_items.push_back(mk_item(0, 0, 16, 16, 10, 10, 8, 8, 30, 30));
    pending_items.push_back(mk_item(16, 16, 0, 0, 20, 5, 40, 0, 20, 30));
    pending_items.push_back(mk_item(-32768, -32768, 32767, 32767, 32767, -32768,
                                    -32768, -32768, 32767, 32767));
    pending_items.push_back(mk_item(32767, 32767, -32768, -32768, -32768, 32767,
                                    32767, -32768, -32768, 32767));
    pending_items.push_back(mk_item(-32768, 0, -32760, 8, 32767, 0, 32000, 0, 32767, 8));
    pending_items.push_back(mk_item(0, 0, 16, 16, 3, 0, 17, 0, 30, 16));
    pending_items.push_back(mk_item(0, 0, 16, 16, 7, -3, 20, -10, 40, 2));
    pending_items.push_back(mk_item(0, 0, 16, 16, 32, 0, 60, 0, 80, 16));
    pending_items.push_back(mk_item(0, 0, 16, 16, -16, -16, -16, -16, 0, 0));
    pending_items.push_back(mk_item(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));

    n_rand = 750;
    for (int i = 0; i < n_rand; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        item_t it;
        it.mover_left = rnd_coord();  it.mover_top = rnd_coord();
        it.mover_right = rnd_coord(); it.mover_bottom = rnd_coord();
        it.speed_x = rnd_coord();     it.speed_y = rnd_coord();
        it.other_left = rnd_coord();  it.other_top = rnd_coord();
        it.other_right = rnd_coord(); it.other_bottom = rnd_coord();
        pending_items.push_back(it);
      end else begin
        pending_items.push_back(rnd_sweep());
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    hold_tx = 1'b0;

    // pause the sender once the directed part is in, until the pipe drains
    wait (n_sent >= 18);
    hold_tx = 1'b1;
    wait (pending_items.size() < 700 || hit_expect.size() == 0);
    @(posedge clk);
    wait (hit_expect.size() == 0 && !in_ch.valid);
    hold_tx = 1'b0;

    wait (pending_items.size() == 0);
    @(posedge clk);
    wait (!in_ch.valid);
    wait (hit_expect.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);

    $display("sent %0d box pairs, checked %0d results, %0d of them hits",
             n_sent, n_recv, n_hits);
    if (errors == 0 && hit_expect.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
